/* sv/odo_pkg.sv */
// odo_pkg: shared types and codes for the wheel odometry tracker
// no dependencies; imported by every module of the block
package odo_pkg;

	localparam int PADDR_W = 4;

	localparam logic [1:0] ACT_WRAP_R = 2'd0;
	localparam logic [1:0] ACT_WRAP_L = 2'd1;
	localparam logic [1:0] ACT_SAMPLE = 2'd2;
	localparam logic [1:0] ACT_CLEAR  = 2'd3;

	localparam logic [1:0] REG_TICKS_PER_TURN = 2'd0;
	localparam logic [1:0] REG_TICK_LEN       = 2'd1;
	localparam logic [1:0] REG_TURN_GAIN      = 2'd2;

	localparam logic [15:0] TICKS_PER_TURN_RST = 16'd360;
	localparam logic [15:0] TICK_LEN_RST       = 16'd3277;
	localparam logic [23:0] TURN_GAIN_RST      = 24'd37283;

	typedef struct packed {
		logic [15:0] ticks_per_turn;
		logic [15:0] tick_len;
		logic [23:0] turn_gain;
	} odo_cfg_t;

	typedef struct packed {
		logic capture;
		logic wrap_r;
		logic wrap_l;
		logic clear;
		logic mul;
		logic add;
		logic diff;
		logic prod;
		logic acc;
	} odo_cmd_t;

endpackage

/* sv/odo_regs.sv */
// odo_regs: configuration registers behind the apb-style port
// depends on odo_pkg
module odo_regs
	import odo_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output odo_cfg_t           cfg
);

	odo_cfg_t   cfg_q;
	logic [1:0] idx;
	logic       wr_en;

	assign idx    = paddr[3:2];
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_turn <= TICKS_PER_TURN_RST;
			cfg_q.tick_len       <= TICK_LEN_RST;
			cfg_q.turn_gain      <= TURN_GAIN_RST;
		end else if (wr_en) begin
			case (idx)
				REG_TICKS_PER_TURN: cfg_q.ticks_per_turn <= pwdata[15:0];
				REG_TICK_LEN:       cfg_q.tick_len       <= pwdata[15:0];
				REG_TURN_GAIN:      cfg_q.turn_gain      <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_TICKS_PER_TURN: prdata = {16'd0, cfg_q.ticks_per_turn};
			REG_TICK_LEN:       prdata = {16'd0, cfg_q.tick_len};
			REG_TURN_GAIN:      prdata = {8'd0, cfg_q.turn_gain};
			default:            prdata = 32'd0;
		endcase
	end

endmodule

/* sv/odo_ctrl.sv */
// odo_ctrl: sequencer for wrap, clear and the five-step sample path
// depends on odo_pkg; drives odo_datapath through odo_cmd_t
module odo_ctrl
	import odo_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] action,
	output logic       req_stall,
	output logic       res_valid,
	input  logic       res_stall,
	output odo_cmd_t   cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_ADD  = 3'd2;
	localparam logic [2:0] ST_DIFF = 3'd3;
	localparam logic [2:0] ST_PROD = 3'd4;
	localparam logic [2:0] ST_ACC  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       res_valid_q;
	logic       accept;
	logic       out_free;

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (action)
						ACT_WRAP_R: cmd.wrap_r = 1'b1;
						ACT_WRAP_L: cmd.wrap_l = 1'b1;
						ACT_CLEAR:  cmd.clear  = 1'b1;
						ACT_SAMPLE: begin
							cmd.capture = 1'b1;
							state_d     = ST_MUL;
						end
						default: ;
					endcase
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.add = 1'b1;
				state_d = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = ST_PROD;
			end
			ST_PROD: begin
				cmd.prod = 1'b1;
				state_d  = ST_ACC;
			end
			ST_ACC: begin
				if (out_free) begin
					cmd.acc = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.acc) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* sv/odo_datapath.sv */
// odo_datapath: turn counters, tick distances, heading integrator, result register
// depends on odo_pkg; stepped by odo_ctrl
module odo_datapath
	import odo_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  odo_cmd_t           cmd,
	input  odo_cfg_t           cfg,
	input  logic               count_up,
	input  logic [15:0]        right_count,
	input  logic [15:0]        left_count,
	output logic signed [47:0] distance_q16,
	output logic signed [47:0] heading_q24
);

	logic [15:0] rturns_q;
	logic [15:0] lturns_q;
	logic [31:0] prev_r_q;
	logic [31:0] prev_l_q;
	logic [47:0] heading_q;
	logic [15:0] rcount_q;
	logic [15:0] lcount_q;

	logic signed [32:0] mr_s1;
	logic signed [32:0] ml_s1;
	logic signed [33:0] rt_s2;
	logic signed [33:0] lt_s2;
	logic signed [34:0] sum_s3;
	logic [31:0]        delta_s3;
	logic signed [51:0] prod_s4;
	logic signed [56:0] omega_s4;

	logic signed [15:0] rturns_s;
	logic signed [15:0] lturns_s;
	logic signed [16:0] tpt_s;
	logic signed [16:0] rcnt_s;
	logic signed [16:0] lcnt_s;
	logic signed [16:0] cm_s;
	logic signed [24:0] gain_s;
	logic signed [31:0] delta_s;
	logic [47:0]        heading_nx;

	assign rturns_s   = rturns_q;
	assign lturns_s   = lturns_q;
	assign tpt_s      = {1'b0, cfg.ticks_per_turn};
	assign rcnt_s     = {1'b0, rcount_q};
	assign lcnt_s     = {1'b0, lcount_q};
	assign cm_s       = {1'b0, cfg.tick_len};
	assign gain_s     = {1'b0, cfg.turn_gain};
	assign delta_s    = delta_s3;
	assign heading_nx = heading_q + omega_s4[47:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rturns_q  <= '0;
			lturns_q  <= '0;
			prev_r_q  <= '0;
			prev_l_q  <= '0;
			heading_q <= '0;
		end else begin
			if (cmd.clear) begin
				rturns_q  <= '0;
				lturns_q  <= '0;
				prev_r_q  <= '0;
				prev_l_q  <= '0;
				heading_q <= '0;
			end
			if (cmd.wrap_r) begin
				rturns_q <= count_up ? rturns_q + 16'd1 : rturns_q - 16'd1;
			end
			// left wheel is mirrored
			if (cmd.wrap_l) begin
				lturns_q <= count_up ? lturns_q - 16'd1 : lturns_q + 16'd1;
			end
			if (cmd.acc) begin
				heading_q <= heading_nx;
				prev_r_q  <= rt_s2[31:0];
				prev_l_q  <= lt_s2[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rcount_q <= right_count;
			lcount_q <= left_count;
		end
		if (cmd.mul) begin
			mr_s1 <= rturns_s * tpt_s;
			ml_s1 <= lturns_s * tpt_s;
		end
		if (cmd.add) begin
			rt_s2 <= mr_s1 + rcnt_s;
			lt_s2 <= ml_s1 - lcnt_s;
		end
		if (cmd.diff) begin
			sum_s3   <= rt_s2 + lt_s2;
			delta_s3 <= (rt_s2[31:0] - prev_r_q) - (lt_s2[31:0] - prev_l_q);
		end
		if (cmd.prod) begin
			prod_s4  <= sum_s3 * cm_s;
			omega_s4 <= delta_s * gain_s;
		end
		// floor of half the product
		if (cmd.acc) begin
			distance_q16 <= prod_s4[48:1];
			heading_q24  <= heading_nx;
		end
	end

endmodule

/* sv/wheel_odometry_tracker_top.sv */
// wheel_odometry_tracker_top: differential-drive odometry for two encoder wheels
// depends on odo_pkg, odo_regs, odo_ctrl, odo_datapath
//
// Request channel (req_valid/req_stall) carries action, count_up, right_count
// and left_count. A right or left wrap request and a clear request are done in
// the cycle they are accepted and produce no result. A sample request runs five
// steps through the sequencer: multiply turns by ticks per turn, add the
// positions, form the sum and the change of (right - left), multiply by the
// tick length and turn gain, then integrate the heading and load the result
// register. After a wrap or clear a new request is taken in the next cycle;
// after a sample req_stall holds it off until the multiply/add chain is done.
// Result channel (res_valid/res_stall) carries distance_q16 and heading_q24,
// valid once the last step of the sample loads them. A waiting result does
// not block a new request; when the receiver stalls, the next sample holds in
// its last step until the result register frees. Reset clears all turn counts,
// tick history and the heading and loads the register defaults. Configuration
// is written over the apb-style port at byte addresses 0, 4 and 8.
module wheel_odometry_tracker_top
	import odo_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         action,
	input  logic               count_up,
	input  logic [15:0]        right_count,
	input  logic [15:0]        left_count,
	output logic               res_valid,
	input  logic               res_stall,
	output logic signed [47:0] distance_q16,
	output logic signed [47:0] heading_q24,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	odo_cfg_t cfg;
	odo_cmd_t cmd;

	odo_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	odo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.action    (action),
		.req_stall (req_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.cmd       (cmd)
	);

	odo_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg          (cfg),
		.count_up     (count_up),
		.right_count  (right_count),
		.left_count   (left_count),
		.distance_q16 (distance_q16),
		.heading_q24  (heading_q24)
	);

`ifndef SYNTHESIS
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && action == ACT_SAMPLE) |=> req_stall)
		else $error("sample request did not occupy the sequencer");

	a_no_result_side: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && action != ACT_SAMPLE && !res_valid) |=> !res_valid)
		else $error("result appeared for a request without one");

	a_result_from_sample: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(req_stall))
		else $error("result appeared outside a sample sequence");
`endif

endmodule
